>>> sv/picc_pkg.sv
// picc_pkg: types and constants shared by the PI controller core
// word layouts, configuration set, register indexes, sequencer states and commands
// no dependencies
`default_nettype none

package picc_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [2:0] REG_INTEG_LIMIT = 3'd2;
    localparam logic [2:0] REG_DRIVE_MIN   = 3'd3;
    localparam logic [2:0] REG_DRIVE_MAX   = 3'd4;

    // action codes of a step word
    localparam logic ACT_COMPUTE = 1'b0;
    localparam logic ACT_CLEAR   = 1'b1;

    // input word
    typedef struct packed {
        logic               action;
        logic signed [15:0] setpoint;
        logic signed [15:0] sample;
        logic        [15:0] step_time;
    } picc_in_t;

    // result word
    typedef struct packed {
        logic signed [31:0] drive;
        logic signed [31:0] integ_now;
    } picc_out_t;

    // configuration set seen by the datapath
    typedef struct packed {
        logic signed [31:0] prop_gain;
        logic signed [31:0] integ_gain;
        logic        [30:0] integ_limit;
        logic signed [31:0] drive_min;
        logic signed [31:0] drive_max;
    } picc_cfg_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_DT,
        ST_INTEG,
        ST_MUL_P,
        ST_MUL_I,
        ST_SUM,
        ST_OUT
    } picc_state_t;

    // operand selection of the shared multiplier
    typedef enum logic [1:0] {
        MUL_ERR_DT,
        MUL_PROP,
        MUL_INTEG
    } picc_mul_sel_t;

    // commands from sequencer to datapath
    typedef struct packed {
        logic          load_step;
        logic          clear_integ;
        logic          mul_en;
        logic          p_load;
        picc_mul_sel_t mul_sel;
        logic          integ_upd;
        logic          sum_en;
        logic          out_load;
    } picc_cmd_t;

endpackage

`default_nettype wire

>>> sv/picc_regs.sv
// picc_regs: configuration register file of the PI controller core
// depends on picc_pkg for register indexes and the configuration struct
`default_nettype none

module picc_regs
    import picc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output picc_cfg_t        cfg
);

    picc_cfg_t cfg_reg;
    picc_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // register write decode, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_PROP_GAIN:   cfg_next.prop_gain   = cfg_data;
                REG_INTEG_GAIN:  cfg_next.integ_gain  = cfg_data;
                REG_INTEG_LIMIT: cfg_next.integ_limit = cfg_data[30:0];
                REG_DRIVE_MIN:   cfg_next.drive_min   = cfg_data;
                REG_DRIVE_MAX:   cfg_next.drive_max   = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain   <= 32'sd0;
            cfg_reg.integ_gain  <= 32'sd0;
            cfg_reg.integ_limit <= 31'd0;
            cfg_reg.drive_min   <= 32'sh8000_0000;
            cfg_reg.drive_max   <= 32'sh7FFF_FFFF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/picc_ctrl.sv
// picc_ctrl: sequencer of the PI controller core
// steps the shared multiplier and accumulate stages, owns the result valid flag
// depends on picc_pkg for states and the command struct
`default_nettype none

module picc_ctrl
    import picc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic step_valid,
    output logic      step_stall,
    input  wire logic step_action,
    output logic      result_valid,
    input  wire logic result_stall,
    output picc_cmd_t cmd
);

    picc_state_t state_reg;
    picc_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        step_take;
    logic        out_free;

    assign step_stall   = (state_reg != ST_IDLE);
    assign step_take    = step_valid && !step_stall;
    assign out_free     = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.mul_sel     = MUL_ERR_DT;
        out_valid_next  = out_valid_reg && result_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (step_take)
                begin
                    if (step_action == ACT_CLEAR)
                    begin
                        cmd.clear_integ = 1'b1;
                    end
                    else
                    begin
                        cmd.load_step = 1'b1;
                        state_next    = ST_MUL_DT;
                    end
                end
            end
            ST_MUL_DT:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_ERR_DT;
                state_next  = ST_INTEG;
            end
            ST_INTEG:
            begin
                cmd.integ_upd = 1'b1;
                state_next    = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                cmd.p_load  = 1'b1;
                cmd.mul_sel = MUL_PROP;
                state_next  = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_INTEG;
                state_next  = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // wait here only while the output register still holds an untaken word
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a compute word starts the multiply sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_take && step_action == ACT_COMPUTE) |=> state_reg == ST_MUL_DT)
        else $error("compute word did not start the sequence");

    // a clear word leaves the sequencer idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_take && step_action == ACT_CLEAR) |=> state_reg == ST_IDLE)
        else $error("clear word left the sequencer busy");

    // finishing a step always presents a result word
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_free) |=> (result_valid && state_reg == ST_IDLE))
        else $error("finished step did not present a result");

endmodule

`default_nettype wire

>>> sv/picc_dp.sv
// picc_dp: datapath of the PI controller core
// one shared signed multiplier, integral accumulate and clamp, drive sum and clamp
// depends on picc_pkg for word, configuration and command types
`default_nettype none

module picc_dp
    import picc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire picc_in_t  step_word,
    input  wire picc_cfg_t cfg,
    input  wire picc_cmd_t cmd,
    output picc_out_t      result_word
);

    logic signed [16:0] err_reg;
    logic        [15:0] dt_reg;
    logic signed [31:0] integ_reg;
    logic signed [31:0] integ_next;
    logic signed [63:0] prod_reg;
    logic signed [48:0] p_reg;
    logic signed [49:0] drv_reg;
    picc_out_t          out_reg;
    picc_out_t          out_next;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_full;
    logic signed [33:0] isum;
    logic signed [33:0] ilim;
    logic signed [49:0] dmax;
    logic signed [49:0] dmin;
    logic signed [49:0] drv_sum;

    // shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_ERR_DT:
            begin
                mul_a = {{16{err_reg[16]}}, err_reg};
                mul_b = {17'd0, dt_reg};
            end
            MUL_PROP:
            begin
                mul_a = {cfg.prop_gain[31], cfg.prop_gain};
                mul_b = {{16{err_reg[16]}}, err_reg};
            end
            MUL_INTEG:
            begin
                mul_a = {cfg.integ_gain[31], cfg.integ_gain};
                mul_b = {integ_reg[31], integ_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // integral accumulate and clamp to plus or minus the limit
    assign isum = {{2{integ_reg[31]}}, integ_reg} + {prod_reg[32], prod_reg[32:0]};
    assign ilim = {3'd0, cfg.integ_limit};

    always_comb
    begin
        if (isum > ilim)
        begin
            integ_next = ilim[31:0];
        end
        else if (isum < -ilim)
        begin
            integ_next = 32'(-ilim);
        end
        else
        begin
            integ_next = isum[31:0];
        end
    end

    // proportional plus floored integral term
    assign drv_sum = {p_reg[48], p_reg} + {{2{prod_reg[63]}}, prod_reg[63:16]};

    // drive clamp, upper bound checked first
    assign dmax = {{18{cfg.drive_max[31]}}, cfg.drive_max};
    assign dmin = {{18{cfg.drive_min[31]}}, cfg.drive_min};

    always_comb
    begin
        out_next.integ_now = integ_reg;
        if (drv_reg > dmax)
        begin
            out_next.drive = cfg.drive_max;
        end
        else if (drv_reg < dmin)
        begin
            out_next.drive = cfg.drive_min;
        end
        else
        begin
            out_next.drive = drv_reg[31:0];
        end
    end

    assign result_word = out_reg;

    // integral state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= 32'sd0;
        end
        else if (cmd.clear_integ)
        begin
            integ_reg <= 32'sd0;
        end
        else if (cmd.integ_upd)
        begin
            integ_reg <= integ_next;
        end
    end

    // working and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_step)
        begin
            err_reg <= {step_word.setpoint[15], step_word.setpoint}
                     - {step_word.sample[15], step_word.sample};
            dt_reg  <= step_word.step_time;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_full[63:0];
        end
        if (cmd.p_load)
        begin
            p_reg <= mul_full[48:0];
        end
        if (cmd.sum_en)
        begin
            drv_reg <= drv_sum;
        end
        if (cmd.out_load)
        begin
            out_reg <= out_next;
        end
    end

    // a clear leaves the integral at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_integ |=> integ_reg == 32'sd0)
        else $error("integral not zero after clear");

    // an updated integral lies within the limit in force at the update
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.integ_upd |=>
            ($signed({integ_reg[31], integ_reg}) <=
                 $signed({2'b00, $past(cfg.integ_limit)}) &&
             $signed({integ_reg[31], integ_reg}) >=
                 -$signed({2'b00, $past(cfg.integ_limit)})))
        else $error("integral outside its limit");

endmodule

`default_nettype wire

>>> sv/pi_controller_with_clamps_core.sv
// pi_controller_with_clamps_core: top level of the PI controller with clamps
// joins picc_regs, picc_ctrl and picc_dp; depends on picc_pkg
`default_nettype none

// PI regulator in fixed point. A compute word forms error = setpoint - sample,
// adds error * step_time to the stored integral and clamps it to plus or minus
// integ_limit, then drives prop_gain * error + integ_gain * integral (floored to
// Q16.16), clamped first to drive_max and then to drive_min. A clear word zeroes
// the integral and gives no result. Words are taken one at a time, only while the
// sequencer is idle: the three products go through a single shared 33 x 33
// multiplier, with the integral update after the first of them, followed by the
// drive sum and the clamp stage. The result sits in an output register, so a new
// word is taken while the previous result waits; if that result is still stalled
// when the new step finishes, the sequencer holds in its last stage and takes no
// word until the output register frees. Configuration writes are always ready and
// take effect on the next cycle.

module pi_controller_with_clamps_core
    import picc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step_valid,
    output logic             step_stall,
    input  wire picc_in_t    step_word,
    output logic             result_valid,
    input  wire logic        result_stall,
    output picc_out_t        result_word,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    picc_cfg_t cfg;
    picc_cmd_t cmd;

    // configuration registers
    picc_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer
    picc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_valid   (step_valid),
        .step_stall   (step_stall),
        .step_action  (step_word.action),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd)
    );

    // datapath
    picc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_word   (step_word),
        .cfg         (cfg),
        .cmd         (cmd),
        .result_word (result_word)
    );

endmodule

`default_nettype wire

>>> tb/testbench.sv
// testbench: self-checking bench for pi_controller_with_clamps_core
// drives step words and register writes, predicts each result word, checks it
// depends on picc_pkg and the core rtl
`timescale 1ns / 1ps

module testbench
    import picc_pkg::*;
();

    localparam int SETTLE_CYCLES   = 12;
    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 48;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        step_valid   = 1'b0;
    picc_in_t    step_word    = '0;
    logic        result_stall = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic [2:0]  cfg_index    = '0;
    logic [31:0] cfg_data     = '0;
    logic        step_stall;
    logic        result_valid;
    logic        cfg_ready;
    picc_out_t   result_word;

    // local copy of the configuration and the stored integral
    logic signed [31:0] m_prop_gain  = '0;
    logic signed [31:0] m_integ_gain = '0;
    logic        [30:0] m_integ_lim  = '0;
    logic signed [31:0] m_drive_min  = 32'sh8000_0000;
    logic signed [31:0] m_drive_max  = 32'sh7FFF_FFFF;
    logic signed [31:0] m_integ_acc  = '0;

    picc_out_t  expected_drive_q[$];
    picc_out_t  oldest_word;
    idle_mode_t idle_mode     = IDLE_NONE;
    int         fail_count    = 0;
    int         compute_count = 0;
    int         clear_count   = 0;
    int         write_count   = 0;
    int         checked_count = 0;

    pi_controller_with_clamps_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_valid   (step_valid),
        .step_stall   (step_stall),
        .step_word    (step_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int send_idle_pct();
        case (idle_mode)
            IDLE_SEND: return 60;
            IDLE_BOTH: return 16;
            default:   return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct();
        case (idle_mode)
            IDLE_RECV: return 60;
            IDLE_BOTH: return 16;
            default:   return 0;
        endcase
    endfunction

    // receiver back-pressure
    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < recv_stall_pct());
    end

    // one PI step: integral update with clamp, then drive with max-then-min clamp
    function automatic picc_out_t compute_drive(input picc_in_t w);
        longint    err;
        longint    acc;
        longint    lim;
        longint    drv;
        picc_out_t r;
        err = longint'(w.setpoint) - longint'(w.sample);
        acc = longint'(m_integ_acc) + err * longint'(w.step_time);
        lim = longint'(m_integ_lim);
        if (acc > lim)
            acc = lim;
        else if (acc < -lim)
            acc = -lim;
        m_integ_acc = acc[31:0];
        // q32.32 product floored back to q16.16
        drv = longint'(m_prop_gain) * err
            + ((longint'(m_integ_gain) * longint'(m_integ_acc)) >>> 16);
        if (drv > longint'(m_drive_max))
            drv = longint'(m_drive_max);
        else if (drv < longint'(m_drive_min))
            drv = longint'(m_drive_min);
        r.drive     = drv[31:0];
        r.integ_now = m_integ_acc;
        return r;
    endfunction

    // result checker against the oldest expected word
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_drive_q.size() == 0)
            begin
                $error("result word with nothing expected: drive %0d integ_now %0d",
                       result_word.drive, result_word.integ_now);
                fail_count++;
            end
            else
            begin
                oldest_word = expected_drive_q.pop_front();
                checked_count++;
                if (result_word.drive !== oldest_word.drive)
                begin
                    $error("drive mismatch: expected %0d actual %0d",
                           oldest_word.drive, result_word.drive);
                    fail_count++;
                end
                if (result_word.integ_now !== oldest_word.integ_now)
                begin
                    $error("integ_now mismatch: expected %0d actual %0d",
                           oldest_word.integ_now, result_word.integ_now);
                    fail_count++;
                end
            end
        end
    end

    function automatic picc_in_t make_word(input logic act, input logic [15:0] sp,
                                           input logic [15:0] smp, input logic [15:0] dt);
        picc_in_t w;
        w.action    = act;
        w.setpoint  = sp;
        w.sample    = smp;
        w.step_time = dt;
        return w;
    endfunction

    // send one step word, with random idle cycles ahead of it
    task automatic send_word(input picc_in_t w);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct())
            gap++;
        if (gap > 0)
        begin
            step_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        step_valid <= 1'b1;
        step_word  <= w;
        do
            @(posedge clk);
        while (step_stall);
        if (w.action == ACT_CLEAR)
        begin
            m_integ_acc = '0;
            clear_count++;
        end
        else
        begin
            expected_drive_q.push_back(compute_drive(w));
            compute_count++;
        end
    endtask

    // hold off the sender until every expected word has come back
    task automatic drain_results();
        step_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_drive_q.size() != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_PROP_GAIN:   m_prop_gain  = data;
            REG_INTEG_GAIN:  m_integ_gain = data;
            REG_INTEG_LIMIT: m_integ_lim  = data[30:0];
            REG_DRIVE_MIN:   m_drive_min  = data;
            REG_DRIVE_MAX:   m_drive_max  = data;
            default:         ;
        endcase
        write_count++;
    endtask

    // full register set, written only once the core has gone quiet
    task automatic load_settings(input logic [31:0] pg, input logic [31:0] ig,
                                 input logic [31:0] lim, input logic [31:0] dmin,
                                 input logic [31:0] dmax);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_PROP_GAIN, pg);
        write_reg(REG_INTEG_GAIN, ig);
        write_reg(REG_INTEG_LIMIT, lim);
        write_reg(REG_DRIVE_MIN, dmin);
        write_reg(REG_DRIVE_MAX, dmax);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_s32();
        logic [31:0] v;
        case ($urandom_range(7))
            0:       v = 32'h7FFF_FFFF;
            1:       v = 32'h8000_0000;
            2:       v = '0;
            default:
            begin
                v = $urandom >> $urandom_range(31);
                if ($urandom_range(1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic logic [15:0] rand_s16();
        logic [15:0] v;
        case ($urandom_range(7))
            0:       v = 16'h7FFF;
            1:       v = 16'h8000;
            2:       v = '0;
            default:
            begin
                v = 16'($urandom >> $urandom_range(31, 16));
                if ($urandom_range(1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic logic [15:0] rand_dt();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom >> $urandom_range(31, 16));
        endcase
    endfunction

    // reset values: zero gains and zero limit give a zero drive
    task automatic test_reset_state();
        send_word(make_word(ACT_COMPUTE, 16'h7FFF, 16'h8000, 16'hFFFF));
        send_word(make_word(ACT_COMPUTE, 16'h8000, 16'h7FFF, 16'h1234));
    endtask

    // widest gains, limit and error in both directions
    task automatic test_field_extremes();
        load_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                      32'h8000_0000, 32'h7FFF_FFFF);
        repeat (2) send_word(make_word(ACT_COMPUTE, 16'h7FFF, 16'h8000, 16'hFFFF));
        send_word(make_word(ACT_COMPUTE, 16'h7FFF, 16'h8000, 16'h0000));
        repeat (3) send_word(make_word(ACT_COMPUTE, 16'h8000, 16'h7FFF, 16'hFFFF));
        send_word(make_word(ACT_COMPUTE, 16'h0000, 16'h0000, 16'hFFFF));
        load_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h7FFF_FFFF);
        send_word(make_word(ACT_COMPUTE, 16'h8000, 16'h7FFF, 16'hFFFF));
        send_word(make_word(ACT_COMPUTE, 16'h7FFF, 16'h8000, 16'h8000));
    endtask

    // integral pinned at both limits, then cleared
    task automatic test_integral_clamp();
        load_settings(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                      32'h8000_0000, 32'h7FFF_FFFF);
        send_word(make_word(ACT_COMPUTE, 16'd100, 16'd0, 16'hFFFF));
        send_word(make_word(ACT_COMPUTE, 16'd0, 16'd100, 16'hFFFF));
        send_word(make_word(ACT_CLEAR, 16'h5A5A, 16'hA5A5, 16'hFFFF));
        send_word(make_word(ACT_COMPUTE, 16'd1, 16'd0, 16'h0001));
        send_word(make_word(ACT_COMPUTE, 16'd0, 16'd3, 16'h8000));
    endtask

    // crossed drive bounds: max is checked first, min only below it
    task automatic test_drive_clamp();
        load_settings(32'h0001_0000, 32'h0000_0000, 32'h0000_0000,
                      32'h0064_0000, 32'hFF9C_0000);
        send_word(make_word(ACT_COMPUTE, 16'd500, 16'd0, 16'h0000));
        send_word(make_word(ACT_COMPUTE, 16'd0, 16'd500, 16'h0000));
        send_word(make_word(ACT_COMPUTE, 16'd0, 16'd0, 16'h0000));
        load_settings(32'h0001_0000, 32'h0000_0000, 32'h0000_0000,
                      32'hFF9C_0000, 32'h0064_0000);
        send_word(make_word(ACT_COMPUTE, 16'd500, 16'd0, 16'h0000));
        send_word(make_word(ACT_COMPUTE, 16'd0, 16'd500, 16'h0000));
        send_word(make_word(ACT_COMPUTE, 16'd7, 16'd0, 16'h0000));
    endtask

    // writes past the last register index change nothing
    task automatic test_unused_index();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        for (int i = REG_DRIVE_MAX + 1; i < 8; i++)
            write_reg(3'(i), $urandom);
        cfg_valid <= 1'b0;
        @(posedge clk);
        send_word(make_word(ACT_COMPUTE, 16'd500, 16'd0, 16'h0000));
        send_word(make_word(ACT_COMPUTE, 16'd0, 16'd500, 16'h0000));
    endtask

    // random words over several register settings and idle patterns
    task automatic test_random();
        logic [31:0] dmin;
        logic [31:0] dmax;
        logic [31:0] tmp;
        int          done;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                load_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                              32'h8000_0000, 32'h7FFF_FFFF);
            else if (phase == 1)
                load_settings(32'h8000_0000, 32'h8000_0000, 32'h0000_0000,
                              32'h7FFF_FFFF, 32'h8000_0000);
            else
            begin
                dmin = rand_s32();
                dmax = rand_s32();
                if ($urandom_range(3) != 0 && $signed(dmin) > $signed(dmax))
                begin
                    tmp  = dmin;
                    dmin = dmax;
                    dmax = tmp;
                end
                load_settings(rand_s32(), rand_s32(), rand_s32(), dmin, dmax);
            end
            idle_mode = idle_mode_t'(phase % 4);
            done = 0;
            while (done < WORDS_PER_PHASE)
            begin
                if ($urandom_range(49) == 0)
                    drain_results();
                if ($urandom_range(9) == 0)
                    send_word(make_word(ACT_CLEAR, 16'($urandom), 16'($urandom),
                                        16'($urandom)));
                else
                begin
                    send_word(make_word(ACT_COMPUTE, rand_s16(), rand_s16(), rand_dt()));
                    done++;
                end
            end
        end
        idle_mode = IDLE_NONE;
    endtask

    // test sequence
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_field_extremes();
        test_integral_clamp();
        test_drive_clamp();
        test_unused_index();
        test_random();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d compute words and %0d clears under %0d register writes,",
                 compute_count, clear_count, write_count);
        $display("%0d result words checked across four idle patterns", checked_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
sv/picc_pkg.sv
sv/picc_regs.sv
sv/picc_ctrl.sv
sv/picc_dp.sv
sv/pi_controller_with_clamps_core.sv
tb/testbench.sv
